// ----- sv/tpe_pkg.sv -----
// tpe_pkg: shared widths, opcodes and the arithmetic command word
// for the tensor polynomial evaluator; no dependencies
package tpe_pkg;

	localparam int NUM_VARS_DEF   = 2;
	localparam int NUM_POINTS_DEF = 4;

	localparam int OP_W   = 2;
	localparam int DEG_W  = 4;
	localparam int COEF_W = 32;
	localparam int VAR_W  = 16;
	localparam int VAL_W  = 48;
	localparam int MAX_VARS = 4;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_EVAL  = 2'd2
	} opcode_t;

	// one strobe per operation of the shared arithmetic unit
	typedef struct packed {
		logic start; // clear running sum and flag
		logic load;  // term <= coefficient
		logic mul;   // product <= term * variable
		logic rnd;   // term <= clamp(round(product))
		logic acc;   // sum <= clamp(sum + term)
	} tpe_cmd_t;

endpackage

// ----- sv/tpe_coef_mem.sv -----
// tpe_coef_mem: coefficient store, one write port and one registered read port
// depends on tpe_pkg
module tpe_coef_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [tpe_pkg::COEF_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [tpe_pkg::COEF_W-1:0] rdata
);
	import tpe_pkg::*;

	logic [COEF_W-1:0] mem [DEPTH];
	logic [COEF_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/tpe_arith.sv -----
// tpe_arith: shared multiply / round / clamp / accumulate unit
// depends on tpe_pkg (command word, widths)
module tpe_arith (
	input  logic                             clk,
	input  tpe_pkg::tpe_cmd_t                cmd,
	input  logic signed [tpe_pkg::COEF_W-1:0] coef,
	input  logic signed [tpe_pkg::VAR_W-1:0]  var_sel,
	output logic signed [tpe_pkg::VAL_W-1:0]  sum,
	output logic                              sat
);
	import tpe_pkg::*;

	localparam int PROD_W = VAL_W + VAR_W;
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	logic signed [VAL_W-1:0]  term_q;
	logic signed [VAL_W-1:0]  sum_q;
	logic                     sat_q;
	logic signed [PROD_W-1:0] prod_s1;

	logic signed [PROD_W-1:0] prod_w;
	logic signed [PROD_W-1:0] rnd_w;
	logic                     rnd_ovf;
	logic signed [VAL_W-1:0]  rnd_val;
	logic signed [VAL_W:0]    add_w;
	logic                     add_ovf;
	logic signed [VAL_W-1:0]  add_val;

	assign prod_w = PROD_W'(term_q) * PROD_W'(var_sel);

	// floor((p + 2048) / 4096), then clamp to the result range
	always_comb begin
		rnd_w   = (prod_s1 + PROD_W'(2048)) >>> 12;
		rnd_ovf = (rnd_w[PROD_W-1:VAL_W-1] != {(PROD_W-VAL_W+1){rnd_w[PROD_W-1]}});
		rnd_val = rnd_ovf ? (rnd_w[PROD_W-1] ? VAL_MIN : VAL_MAX) : rnd_w[VAL_W-1:0];
	end

	always_comb begin
		add_w   = (VAL_W+1)'(sum_q) + (VAL_W+1)'(term_q);
		add_ovf = (add_w[VAL_W] != add_w[VAL_W-1]);
		add_val = add_ovf ? (add_w[VAL_W] ? VAL_MIN : VAL_MAX) : add_w[VAL_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sum_q <= '0;
			sat_q <= 1'b0;
		end
		if (cmd.load) begin
			term_q <= VAL_W'(coef);
		end
		if (cmd.mul) begin
			prod_s1 <= prod_w;
		end
		if (cmd.rnd) begin
			term_q <= rnd_val;
			if (rnd_ovf) begin
				sat_q <= 1'b1;
			end
		end
		if (cmd.acc) begin
			sum_q <= add_val;
			if (add_ovf) begin
				sat_q <= 1'b1;
			end
		end
	end

	assign sum = sum_q;
	assign sat = sat_q;

endmodule

// ----- sv/tensor_polynomial_evaluator.sv -----
// tensor_polynomial_evaluator: top level, sequencer and handshake
// depends on tpe_pkg, tpe_coef_mem, tpe_arith
//
// Holds NUM_POINTS**NUM_VARS signed Q15.16 coefficients addressed by one
// degree per variable (variable 0 least significant). A write word stores a
// coefficient (ignored when a used degree is out of range), a read word
// returns it as Q31.16 (zero when out of range), and an evaluate word returns
// the sum over all entries of coefficient * prod var_n**degree_n in Q31.16,
// with saturated set if any product or partial sum was clamped. After reset
// the block runs a clearing pass over all NUM_POINTS**NUM_VARS entries with
// item_stall high. An evaluate uses one 48x16 multiplier with a round/clamp
// step after it; it walks the entries from the highest index down, fetching
// each coefficient, skipping it if zero and otherwise raising each variable to
// its degree by multiply and round/clamp steps before adding the term to the
// sum. The block takes one word at a time; a finished result sits in the
// output register so the next word can be taken while it waits.
module tensor_polynomial_evaluator #(
	parameter int NUM_VARS   = tpe_pkg::NUM_VARS_DEF,
	parameter int NUM_POINTS = tpe_pkg::NUM_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input words
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [tpe_pkg::OP_W-1:0]          opcode,
	input  logic [tpe_pkg::DEG_W-1:0]         degree_0,
	input  logic [tpe_pkg::DEG_W-1:0]         degree_1,
	input  logic [tpe_pkg::DEG_W-1:0]         degree_2,
	input  logic [tpe_pkg::DEG_W-1:0]         degree_3,
	input  logic signed [tpe_pkg::COEF_W-1:0] coef_value,
	input  logic signed [tpe_pkg::VAR_W-1:0]  var_0,
	input  logic signed [tpe_pkg::VAR_W-1:0]  var_1,
	input  logic signed [tpe_pkg::VAR_W-1:0]  var_2,
	input  logic signed [tpe_pkg::VAR_W-1:0]  var_3,
	// result words
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [tpe_pkg::VAL_W-1:0]  value,
	output logic                              saturated
);
	import tpe_pkg::*;

	localparam int TABLE_SIZE = NUM_POINTS ** NUM_VARS;
	localparam int AW  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int VNW = $clog2(NUM_VARS + 1);        // holds 0..NUM_VARS
	localparam int VIW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
	localparam logic [AW-1:0]    LAST_IDX = AW'(TABLE_SIZE - 1);
	localparam logic [DEG_W-1:0] TOP_DEG  = DEG_W'(NUM_POINTS - 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD, S_FETCH, S_LOAD, S_STEP, S_RND, S_ACC, S_NEXT, S_DONE
	} state_t;

	state_t state_q;

	logic [AW-1:0]             clr_q;      // clearing pass address
	logic [AW-1:0]             idx_q;      // entry being read or evaluated
	logic                      rd_ok_q;    // read degrees were in range
	logic [DEG_W-1:0]          deg_q [NUM_VARS]; // digits of idx_q
	logic signed [VAR_W-1:0]   var_q [NUM_VARS];
	logic [VNW-1:0]            vn_q;       // variable being raised
	logic [DEG_W-1:0]          k_q;        // multiplies done for it
	logic                      result_valid_q;
	logic signed [VAL_W-1:0]   value_q;
	logic                      saturated_q;

	logic [DEG_W-1:0]          in_deg [MAX_VARS];
	logic signed [VAR_W-1:0]   in_var [MAX_VARS];
	logic [AW-1:0]             in_idx;
	logic                      in_ok;
	logic [DEG_W-1:0]          deg_dec [NUM_VARS];
	logic                      accept;
	logic                      out_free;
	logic [VIW-1:0]            vn_idx;
	logic                      vn_end;
	logic                      k_end;

	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [COEF_W-1:0]         mem_wdata;
	logic [AW-1:0]             mem_raddr;
	logic [COEF_W-1:0]         mem_rdata;

	tpe_cmd_t                  cmd;
	logic signed [VAL_W-1:0]   acc_sum;
	logic                      acc_sat;

	assign in_deg = '{degree_0, degree_1, degree_2, degree_3};
	assign in_var = '{var_0, var_1, var_2, var_3};

	// table address from the degrees, most significant variable first
	always_comb begin
		in_idx = '0;
		in_ok  = 1'b1;
		for (int n = NUM_VARS - 1; n >= 0; n--) begin
			in_idx = AW'(in_idx * AW'(NUM_POINTS)) + AW'(in_deg[n]);
			if ({1'b0, in_deg[n]} >= (DEG_W+1)'(NUM_POINTS)) begin
				in_ok = 1'b0;
			end
		end
	end

	// mixed-radix decrement of the degree digits, tracks idx_q - 1
	always_comb begin
		logic borrow;
		borrow = 1'b1;
		for (int n = 0; n < NUM_VARS; n++) begin
			deg_dec[n] = deg_q[n];
			if (borrow) begin
				if (deg_q[n] == '0) begin
					deg_dec[n] = TOP_DEG;
				end else begin
					deg_dec[n] = deg_q[n] - 1'b1;
					borrow     = 1'b0;
				end
			end
		end
	end

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;
	assign vn_idx     = vn_q[VIW-1:0];
	assign vn_end     = (vn_q == VNW'(NUM_VARS));
	assign k_end      = vn_end || (k_q == deg_q[vn_idx]);

	// one write port: clearing pass or a write word
	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = accept && (opcode == OP_WRITE) && in_ok;
			mem_waddr = in_idx;
			mem_wdata = coef_value;
		end
	end

	// read address follows the incoming word while idle
	assign mem_raddr = (state_q == S_IDLE) ? in_idx : idx_q;

	tpe_coef_mem #(
		.DEPTH (TABLE_SIZE),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// arithmetic strobes
	always_comb begin
		cmd       = '0;
		cmd.start = accept && (opcode == OP_EVAL);
		cmd.load  = (state_q == S_LOAD) && (mem_rdata != '0);
		cmd.mul   = (state_q == S_STEP) && !k_end;
		cmd.rnd   = (state_q == S_RND);
		cmd.acc   = (state_q == S_ACC);
	end

	tpe_arith u_arith (
		.clk     (clk),
		.cmd     (cmd),
		.coef    (mem_rdata),
		.var_sel (var_q[vn_idx]),
		.sum     (acc_sum),
		.sat     (acc_sat)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			vn_q           <= '0;
			k_q            <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						idx_q   <= in_idx;
						rd_ok_q <= in_ok;
						case (opcode)
							OP_READ: begin
								state_q <= S_RD;
							end
							OP_EVAL: begin
								idx_q <= LAST_IDX;
								for (int n = 0; n < NUM_VARS; n++) begin
									deg_q[n] <= TOP_DEG;
									var_q[n] <= in_var[n];
								end
								state_q <= S_FETCH;
							end
							default: ; // write done by the port, unused code dropped
						endcase
					end
				end
				S_RD: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						value_q        <= rd_ok_q ? VAL_W'($signed(mem_rdata)) : '0;
						saturated_q    <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				S_FETCH: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					// zero coefficients add nothing, skip them
					if (mem_rdata == '0) begin
						state_q <= S_NEXT;
					end else begin
						vn_q    <= '0;
						k_q     <= '0;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (vn_end) begin
						state_q <= S_ACC;
					end else if (k_end) begin
						vn_q <= VNW'(vn_q + 1'b1);
						k_q  <= '0;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_RND;
					end
				end
				S_RND: begin
					state_q <= S_STEP;
				end
				S_ACC: begin
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (idx_q == '0) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q - 1'b1;
						deg_q   <= deg_dec;
						state_q <= S_FETCH;
					end
				end
				S_DONE: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						value_q        <= acc_sum;
						saturated_q    <= acc_sat;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign saturated    = saturated_q;

	// an evaluate word keeps the input side closed on the next cycle
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_EVAL) |=> item_stall)
		else $error("input open right after an evaluate word");

	// the multiply count never passes the degree of the current variable
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP && !vn_end) |-> (k_q <= deg_q[vn_idx]))
		else $error("multiply count beyond degree");

	// no result can be pending while the table is being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !result_valid_q)
		else $error("result word during clearing pass");

endmodule

// ----- verif/tensor_polynomial_evaluator_tb.sv -----
// tensor_polynomial_evaluator_tb: self-checking bench for the polynomial evaluator
// depends on tpe_pkg and tensor_polynomial_evaluator; directed table, then random
// words checked against a fixed-point shadow of the coefficient table
module tensor_polynomial_evaluator_tb;

	import tpe_pkg::*;

	localparam int NUM_VARS   = NUM_VARS_DEF;
	localparam int NUM_POINTS = NUM_POINTS_DEF;
	localparam int TABLE_SIZE = NUM_POINTS ** NUM_VARS;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 11;
	localparam int RANDOM_WORDS   = 1730;
	localparam int HOLD_AFTER     = 150;   // results seen before the long receiver hold-off
	localparam int HOLD_CYCLES    = 600;
	localparam int DRAIN_CYCLES   = 400;   // longer than the slowest evaluate
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PRINT_LIMIT    = 100;

	// unused opcode: the block takes the word and does nothing
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	// Q3.12 variables: rounding constant and shift of one multiply
	localparam int     VAR_FRAC   = 12;
	localparam longint ROUND_HALF = 64'sd1 <<< (VAR_FRAC - 1);
	localparam longint VAL_MAX    = 64'sh0000_7fff_ffff_ffff;
	localparam longint VAL_MIN    = -VAL_MAX - 1;

	localparam logic [VAR_W-1:0]  VMAX    = 16'h7fff;
	localparam logic [VAR_W-1:0]  VMIN    = 16'h8000;
	localparam logic [VAR_W-1:0]  ONE_Q12 = 16'h1000;
	localparam logic [COEF_W-1:0] CMAX    = 32'h7fff_ffff;
	localparam logic [COEF_W-1:0] CMIN    = 32'h8000_0000;
	localparam logic [COEF_W-1:0] ONE_Q16 = 32'h0001_0000;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             saturated;
	} result_t;

	// one input word plus, for table rows, an expectation typed in by hand
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DEG_W-1:0]  d0, d1, d2, d3;
		logic [COEF_W-1:0] coef;
		logic [VAR_W-1:0]  v0, v1, v2, v3;
		logic              typed;
		logic [VAL_W-1:0]  exp_value;
		logic              exp_sat;
	} word_t;

	localparam int N_DIRECTED = 25;

	// op       d0     d1     d2     d3     coef     v0      v1     v2     v3    typed value sat
	localparam word_t DIRECTED [N_DIRECTED] = '{
		// empty table right after reset
		'{OP_READ,  4'd0,  4'd0,  4'd0,  4'd0,  32'h0,  16'h0, 16'h0, 16'h0, 16'h0,
			1'b1, 48'h0, 1'b0},
		'{OP_EVAL,  4'd0,  4'd0,  4'd0,  4'd0,  32'h0,  VMAX,  VMAX,  VMAX,  VMAX,
			1'b1, 48'h0, 1'b0},
		// read with a used degree out of range gives zero
		'{OP_READ,  4'd15, 4'd0,  4'd0,  4'd0,  32'h0,  16'h0, 16'h0, 16'h0, 16'h0,
			1'b1, 48'h0, 1'b0},
		// coefficient extremes, unused degrees must not matter
		'{OP_WRITE, 4'd0,  4'd0,  4'd0,  4'd0,  CMAX,   16'h0, 16'h0, 16'h0, 16'h0,
			1'b0, 48'h0, 1'b0},
		'{OP_READ,  4'd0,  4'd0,  4'd15, 4'd15, 32'h0,  16'h0, 16'h0, 16'h0, 16'h0,
			1'b1, 48'h0000_7fff_ffff, 1'b0},
		'{OP_WRITE, 4'd3,  4'd3,  4'd0,  4'd0,  CMIN,   16'h0, 16'h0, 16'h0, 16'h0,
			1'b0, 48'h0, 1'b0},
		'{OP_READ,  4'd3,  4'd3,  4'd0,  4'd0,  32'h0,  16'h0, 16'h0, 16'h0, 16'h0,
			1'b1, 48'hffff_8000_0000, 1'b0},
		// out-of-range write whose flat index would alias entry (0,1): dropped
		'{OP_WRITE, 4'd4,  4'd0,  4'd0,  4'd0,  32'h309, 16'h0, 16'h0, 16'h0, 16'h0,
			1'b0, 48'h0, 1'b0},
		'{OP_READ,  4'd0,  4'd1,  4'd0,  4'd0,  32'h0,  16'h0, 16'h0, 16'h0, 16'h0,
			1'b1, 48'h0, 1'b0},
		'{OP_WRITE, 4'd15, 4'd15, 4'd15, 4'd15, CMAX,   16'h0, 16'h0, 16'h0, 16'h0,
			1'b0, 48'h0, 1'b0},
		'{OP_READ,  4'd0,  4'd15, 4'd0,  4'd0,  32'h0,  16'h0, 16'h0, 16'h0, 16'h0,
			1'b1, 48'h0, 1'b0},
		// all variables zero: only the constant entry survives
		'{OP_EVAL,  4'd0,  4'd0,  4'd0,  4'd0,  32'h0,  16'h0, 16'h0, 16'h0, 16'h0,
			1'b1, 48'h0000_7fff_ffff, 1'b0},
		'{OP_EVAL,  4'd0,  4'd0,  4'd0,  4'd0,  32'h0,  VMAX,  VMAX,  VMIN,  VMIN,
			1'b0, 48'h0, 1'b0},
		'{OP_EVAL,  4'd0,  4'd0,  4'd0,  4'd0,  32'h0,  VMIN,  VMIN,  VMAX,  VMAX,
			1'b0, 48'h0, 1'b0},
		// unused opcode must neither answer nor store
		'{OP_NONE,  4'd0,  4'd0,  4'd0,  4'd0,  ONE_Q16, VMIN, VMIN,  VMIN,  VMIN,
			1'b0, 48'h0, 1'b0},
		'{OP_READ,  4'd0,  4'd0,  4'd0,  4'd0,  32'h0,  16'h0, 16'h0, 16'h0, 16'h0,
			1'b1, 48'h0000_7fff_ffff, 1'b0},
		'{OP_WRITE, 4'd1,  4'd2,  4'd0,  4'd0,  ONE_Q16, 16'h0, 16'h0, 16'h0, 16'h0,
			1'b0, 48'h0, 1'b0},
		'{OP_WRITE, 4'd3,  4'd2,  4'd0,  4'd0,  CMAX,   16'h0, 16'h0, 16'h0, 16'h0,
			1'b0, 48'h0, 1'b0},
		'{OP_WRITE, 4'd2,  4'd3,  4'd0,  4'd0,  CMAX,   16'h0, 16'h0, 16'h0, 16'h0,
			1'b0, 48'h0, 1'b0},
		// unity variables, then products and partial sums that clamp
		'{OP_EVAL,  4'd0,  4'd0,  4'd0,  4'd0,  32'h0,  ONE_Q12, ONE_Q12, ONE_Q12, ONE_Q12,
			1'b0, 48'h0, 1'b0},
		'{OP_EVAL,  4'd0,  4'd0,  4'd0,  4'd0,  32'h0,  VMAX,  VMAX,  16'h0, 16'h0,
			1'b0, 48'h0, 1'b0},
		'{OP_EVAL,  4'd0,  4'd0,  4'd0,  4'd0,  32'h0,  VMIN,  VMAX,  16'h0, 16'h0,
			1'b0, 48'h0, 1'b0},
		'{OP_WRITE, 4'd3,  4'd3,  4'd0,  4'd0,  32'h0,  16'h0, 16'h0, 16'h0, 16'h0,
			1'b0, 48'h0, 1'b0},
		'{OP_EVAL,  4'd0,  4'd0,  4'd0,  4'd0,  32'h0,  16'h1, VMAX,  16'h0, 16'h0,
			1'b0, 48'h0, 1'b0},
		'{OP_READ,  4'd3,  4'd3,  4'd0,  4'd0,  32'h0,  16'h0, 16'h0, 16'h0, 16'h0,
			1'b1, 48'h0, 1'b0}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     item_valid;
	logic                     item_stall;
	logic [OP_W-1:0]          opcode;
	logic [DEG_W-1:0]         degree_0, degree_1, degree_2, degree_3;
	logic signed [COEF_W-1:0] coef_value;
	logic signed [VAR_W-1:0]  var_0, var_1, var_2, var_3;
	logic                     result_valid;
	logic                     result_stall;
	logic signed [VAL_W-1:0]  value;
	logic                     saturated;

	// shadow of the coefficient table, updated as words are accepted
	logic signed [COEF_W-1:0] coef_shadow [TABLE_SIZE];
	result_t                  pending_results [$];
	result_t                  oldest;
	int                       error_count  = 0;
	int                       results_seen = 0;
	int                       idle_cycles  = 0;
	bit                       steady_phase = 1'b0;   // no input gaps, no result stalls outside the long hold-off

	tensor_polynomial_evaluator #(
		.NUM_VARS   (NUM_VARS),
		.NUM_POINTS (NUM_POINTS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.degree_0     (degree_0),
		.degree_1     (degree_1),
		.degree_2     (degree_2),
		.degree_3     (degree_3),
		.coef_value   (coef_value),
		.var_0        (var_0),
		.var_1        (var_1),
		.var_2        (var_2),
		.var_3        (var_3),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.saturated    (saturated)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// clamp to the signed 48-bit result range, flagging any change
	function automatic longint clamp_q31(input longint v, inout bit sat);
		if (v > VAL_MAX) begin
			sat = 1'b1;
			return VAL_MAX;
		end
		if (v < VAL_MIN) begin
			sat = 1'b1;
			return VAL_MIN;
		end
		return v;
	endfunction

	// applies one accepted word to the shadow table; returns 1 with the
	// expected result word for reads and evaluates
	function automatic bit polynomial_result(input word_t w, output result_t res);
		logic [DEG_W-1:0] deg [MAX_VARS];
		longint           x [MAX_VARS];
		longint           term;
		longint           sum;
		int               idx;
		int               rest;
		int               d;
		bit               in_range;
		bit               sat;
		res = '0;
		deg[0] = w.d0;
		deg[1] = w.d1;
		deg[2] = w.d2;
		deg[3] = w.d3;
		x[0] = longint'($signed(w.v0));
		x[1] = longint'($signed(w.v1));
		x[2] = longint'($signed(w.v2));
		x[3] = longint'($signed(w.v3));
		// flat index, variable 0 least significant; only used degrees count
		idx = 0;
		in_range = 1'b1;
		for (int n = NUM_VARS - 1; n >= 0; n--) begin
			idx = idx * NUM_POINTS + int'(deg[n]);
			if (int'(deg[n]) >= NUM_POINTS)
				in_range = 1'b0;
		end
		if (idx >= TABLE_SIZE)
			in_range = 1'b0;
		case (w.op)
			OP_WRITE: begin
				if (in_range)
					coef_shadow[idx] = w.coef;
				return 1'b0;
			end
			OP_READ: begin
				term = in_range ? longint'(coef_shadow[idx]) : 64'sd0;
				res.value = term[VAL_W-1:0];
				return 1'b1;
			end
			OP_EVAL: begin
				sum = 0;
				sat = 1'b0;
				// highest entry first, so clamping of partial sums matches the block
				for (int e = TABLE_SIZE - 1; e >= 0; e--) begin
					term = longint'(coef_shadow[e]);
					if (term == 0)
						continue;
					rest = e;
					for (int n = 0; n < NUM_VARS; n++) begin
						d = rest % NUM_POINTS;
						rest = rest / NUM_POINTS;
						repeat (d)
							term = clamp_q31((term * x[n] + ROUND_HALF) >>> VAR_FRAC, sat);
					end
					sum = clamp_q31(sum + term, sat);
				end
				res.value = sum[VAL_W-1:0];
				res.saturated = sat;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
		input logic [VAL_W-1:0] want);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
	endtask

	// used degrees stay in range most of the time so words reach the table
	function automatic logic [DEG_W-1:0] random_degree(input int n);
		if (n >= NUM_VARS || $urandom_range(0, 19) == 0)
			return DEG_W'($urandom_range(0, 15));
		return DEG_W'($urandom_range(0, NUM_POINTS - 1));
	endfunction

	// mostly moderate values around +-2.0 so sums stay meaningful, some
	// full-range and extreme values to reach the clamps
	function automatic logic [VAR_W-1:0] random_var();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return VAR_W'($urandom);
		if (r < 25) begin
			case ($urandom_range(0, 3))
				0: return VMAX;
				1: return VMIN;
				2: return '0;
				default: return ONE_Q12;
			endcase
		end
		return VAR_W'($urandom_range(0, 16383) - 8192);
	endfunction

	// drives one word at the falling edge, holds it until taken, predicts,
	// then leaves a gap of random length unless in a steady phase
	task automatic send_word(input word_t w);
		result_t res;
		int      r;
		int      gap;
		@(negedge clk);
		item_valid <= 1'b1;
		opcode     <= w.op;
		degree_0   <= w.d0;
		degree_1   <= w.d1;
		degree_2   <= w.d2;
		degree_3   <= w.d3;
		coef_value <= w.coef;
		var_0      <= w.v0;
		var_1      <= w.v1;
		var_2      <= w.v2;
		var_3      <= w.v3;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (polynomial_result(w, res)) begin
			// table rows carry their own expectation
			if (w.typed)
				res = '{value: w.exp_value, saturated: w.exp_sat};
			pending_results.push_back(res);
		end
		r = $urandom_range(0, 99);
		if (steady_phase || r < 65)
			gap = 0;
		else if (r < 93)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// sender: reset, directed table, random words, drain
	initial begin
		word_t w;
		int    issued;
		int    r;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		opcode     = OP_WRITE;
		degree_0   = '0;
		degree_1   = '0;
		degree_2   = '0;
		degree_3   = '0;
		coef_value = '0;
		var_0      = '0;
		var_1      = '0;
		var_2      = '0;
		var_3      = '0;
		for (int e = 0; e < TABLE_SIZE; e++)
			coef_shadow[e] = '0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// the clearing pass after reset shows up as item_stall, so just send
		for (int i = 0; i < N_DIRECTED; i++)
			send_word(DIRECTED[i]);

		issued = 0;
		while (issued < RANDOM_WORDS) begin
			// now and then a stretch where both sides run flat out
			if (issued % 128 == 0)
				steady_phase = ($urandom_range(0, 3) == 0);
			w = '0;
			r = $urandom_range(0, 99);
			if (r < 42)
				w.op = OP_WRITE;
			else if (r < 72)
				w.op = OP_READ;
			else if (r < 97)
				w.op = OP_EVAL;
			else
				w.op = OP_NONE;
			w.d0 = random_degree(0);
			w.d1 = random_degree(1);
			w.d2 = random_degree(2);
			w.d3 = random_degree(3);
			// zero coefficients exercise the skip path of the evaluate walk
			r = $urandom_range(0, 99);
			if (r < 20)
				w.coef = '0;
			else if (r < 30)
				w.coef = COEF_W'($urandom);
			else if (r < 36)
				w.coef = $urandom_range(0, 1) ? CMAX : CMIN;
			else
				w.coef = COEF_W'($urandom_range(0, 1 << 19) - (1 << 18));
			w.v0 = random_var();
			w.v1 = random_var();
			w.v2 = random_var();
			w.v3 = random_var();
			send_word(w);
			if (w.op != OP_NONE)
				issued++;
		end
		steady_phase = 1'b0;
		@(negedge clk);
		item_valid <= 1'b0;

		// the watchdog catches a result that never comes
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (error_count == 0)
			$display("tensor_polynomial_evaluator verification clean");
		else
			$display("tensor_polynomial_evaluator verification failed");
		$finish;
	end

	// receiver: random stall runs, plus one long hold-off so the block fills
	// up and pushes back on the input side
	initial begin
		int run;
		int held;
		int r;
		bit run_stall;
		bit hold_done;
		bit next_stall;
		run = 0;
		held = 0;
		run_stall = 1'b0;
		hold_done = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				held = HOLD_CYCLES;
			end
			if (held > 0) begin
				held--;
				next_stall = 1'b1;
			end else if (steady_phase) begin
				next_stall = 1'b0;
			end else begin
				if (run == 0) begin
					r = $urandom_range(0, 99);
					if (r < 80)
						run = $urandom_range(1, 3);
					else if (r < 96)
						run = $urandom_range(4, 12);
					else
						run = $urandom_range(20, 80);
					run_stall = ($urandom_range(0, 9) < 4);
				end
				run--;
				next_stall = run_stall;
			end
			result_stall <= next_stall;
		end
	end

	// result checker: every taken word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word, value", value, '0);
			end else begin
				oldest = pending_results.pop_front();
				if (value !== oldest.value)
					report_mismatch("value", value, oldest.value);
				if (saturated !== oldest.saturated)
					report_mismatch("saturated", saturated, oldest.saturated);
			end
		end
	end

	// watchdog: too long without any word moving on either side
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tensor_polynomial_evaluator verification failed");
			$finish;
		end
	end

endmodule

// ----- sim.f -----
sv/tpe_pkg.sv
sv/tpe_coef_mem.sv
sv/tpe_arith.sv
sv/tensor_polynomial_evaluator.sv
verif/tensor_polynomial_evaluator_tb.sv
